@@ rtl/char_lcd_4bit_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// Character LCD sequencer assertion macros
// Shared concurrent assertion forms for the sequencer checker.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_4BIT_SEQUENCER_MACROS_SVH
`define CHAR_LCD_4BIT_SEQUENCER_MACROS_SVH

// check prop on every rising clock edge outside reset
`define CLS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop on every rising clock edge, reset included
`define CLS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cls_pkg.sv @@
// ----------------------------------------------------------------------------
// cls_pkg
// Types, codes and timing constants of the character LCD 4-bit sequencer.
// ----------------------------------------------------------------------------
package cls_pkg;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_GOTO  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_FUNCTION_SET    = 2'd0,
    CFG_DISPLAY_CONTROL = 2'd1,
    CFG_ENTRY_MODE      = 2'd2,
    CFG_SECOND_ROW      = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic capture;
    logic emit;
  } cls_cmd_t;

  typedef struct packed {
    logic last_step;
  } cls_status_t;

  localparam int unsigned StepW = 4;

  localparam logic [StepW-1:0] LastStepInit  = 4'd13;
  localparam logic [StepW-1:0] LastStepByte  = 4'd3;
  localparam logic [StepW-1:0] LastStepClear = 4'd1;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;

  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

  localparam logic [15:0] WAIT_SHORT     = 16'd2;
  localparam logic [15:0] WAIT_BUSY      = 16'd52;
  localparam logic [15:0] WAIT_WAKE      = 16'd5002;
  localparam logic [15:0] WAIT_CMD       = 16'd252;
  localparam logic [15:0] WAIT_LONG      = 16'd25002;
  localparam logic [15:0] WAIT_INIT_BUSY = 16'd40052;
  localparam logic [15:0] WAIT_DATA      = 16'd50;
  localparam logic [15:0] WAIT_GOTO      = 16'd100;
  localparam logic [15:0] WAIT_CLEAR     = 16'd5002;

  localparam logic [7:0] RST_FUNCTION_SET    = 8'h28;
  localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0F;
  localparam logic [7:0] RST_ENTRY_MODE      = 8'h06;
  localparam logic [6:0] RST_SECOND_ROW      = 7'h40;

endpackage

@@ rtl/char_lcd_4bit_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_4bit_sequencer
// Expands LCD requests into 4-bit bus strobe words.
// ----------------------------------------------------------------------------
// Request channel (req_valid_i / req_stall_o) takes one word: init, write
// byte, goto column/row or clear. Strobe channel (strobe_valid_o /
// strobe_stall_i) returns one word per enable strobe: RS, RW, nibble, the
// wait after it and a last flag on the final strobe of the request.
// Config channel (cfg_valid_i / cfg_ready_o) writes the init bytes and the
// second row base; it is always ready, use it only while idle.
// A taken request is captured into the held request registers, then its
// first strobe word is loaded into the output register; further strobes
// follow one per cycle while the strobe side does not stall. A request
// yields 14 (init), 4 (write, goto) or 2 (clear) strobes, set by the step
// counter; the next request is taken the cycle after the last strobe is
// loaded into the output register. A stall on the strobe side holds the
// output word and freezes the step counter. Reset restores the default
// config bytes and returns the block to idle with no strobe pending.
// ----------------------------------------------------------------------------
module char_lcd_4bit_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic        reg_select_i,
  input  logic [7:0]  data_byte_i,
  input  logic [4:0]  column_i,
  input  logic [1:0]  row_i,
  output logic        strobe_valid_o,
  input  logic        strobe_stall_i,
  output logic        rs_line_o,
  output logic        rw_line_o,
  output logic [3:0]  nibble_o,
  output logic [15:0] wait_after_us_o,
  output logic        last_o
);
  import cls_pkg::*;

  cls_cmd_t         cmd;
  cls_status_t      status;
  logic [StepW-1:0] step;

  cls_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .strobe_stall_i (strobe_stall_i),
    .strobe_valid_o (strobe_valid_o),
    .step_o         (step),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  cls_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .reg_select_i    (reg_select_i),
    .data_byte_i     (data_byte_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .cmd_i           (cmd),
    .step_i          (step),
    .status_o        (status),
    .rs_line_o       (rs_line_o),
    .rw_line_o       (rw_line_o),
    .nibble_o        (nibble_o),
    .wait_after_us_o (wait_after_us_o),
    .last_o          (last_o)
  );

endmodule

@@ rtl/cls_ctrl.sv @@
// ----------------------------------------------------------------------------
// cls_ctrl
// Request state machine: step counter and output word valid.
// ----------------------------------------------------------------------------
module cls_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_stall_o,
  input  logic                        strobe_stall_i,
  output logic                        strobe_valid_o,
  output logic [cls_pkg::StepW-1:0]   step_o,
  output cls_pkg::cls_cmd_t           cmd_o,
  input  cls_pkg::cls_status_t        status_i
);
  import cls_pkg::*;

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || !strobe_stall_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (out_free) begin
          if (status_i.last_step) begin
            state_d = ST_IDLE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        req_stall_o  = 1'b0;
        cmd_o.capture = req_valid_i;
      end
      ST_RUN: begin
        cmd_o.emit = out_free;
      end
      default: req_stall_o = 1'b1;
    endcase
  end

  assign out_valid_d    = cmd_o.emit || (out_valid_q && strobe_stall_i);
  assign strobe_valid_o = out_valid_q;
  assign step_o         = step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/cls_datapath.sv @@
// ----------------------------------------------------------------------------
// cls_datapath
// Config registers, held request and strobe word decode and output register.
// ----------------------------------------------------------------------------
module cls_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic [1:0]                  req_type_i,
  input  logic                        reg_select_i,
  input  logic [7:0]                  data_byte_i,
  input  logic [4:0]                  column_i,
  input  logic [1:0]                  row_i,
  input  cls_pkg::cls_cmd_t           cmd_i,
  input  logic [cls_pkg::StepW-1:0]   step_i,
  output cls_pkg::cls_status_t        status_o,
  output logic                        rs_line_o,
  output logic                        rw_line_o,
  output logic [3:0]                  nibble_o,
  output logic [15:0]                 wait_after_us_o,
  output logic                        last_o
);
  import cls_pkg::*;

  logic [7:0]  fs_q, dc_q, em_q;
  logic [6:0]  row_base_q;
  req_e        req_q, req_d;
  logic        rs_q, rs_d;
  logic [7:0]  byte_q, byte_d;
  logic [7:0]  row_offset, addr_sum;
  logic        sel_rs, sel_rw, last_step;
  logic [3:0]  sel_nib;
  logic [15:0] sel_wait;
  logic        rs_out_q, rw_out_q, last_out_q;
  logic [3:0]  nib_out_q;
  logic [15:0] wait_out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q       <= RST_FUNCTION_SET;
      dc_q       <= RST_DISPLAY_CONTROL;
      em_q       <= RST_ENTRY_MODE;
      row_base_q <= RST_SECOND_ROW;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FUNCTION_SET:    fs_q       <= cfg_data_i;
        CFG_DISPLAY_CONTROL: dc_q       <= cfg_data_i;
        CFG_ENTRY_MODE:      em_q       <= cfg_data_i;
        CFG_SECOND_ROW:      row_base_q <= cfg_data_i[6:0];
        default:             fs_q       <= fs_q;
      endcase
    end
  end

  assign row_offset = (row_i > 2'd1) ? {1'b0, row_base_q} : 8'd0;
  assign addr_sum   = row_offset + {3'b000, column_i} + 8'hFF;

  always_comb begin
    req_d  = req_e'(req_type_i);
    rs_d   = (req_d == REQ_WRITE) ? reg_select_i : 1'b0;
    byte_d = (req_d == REQ_GOTO) ? (CMD_SET_DDRAM | addr_sum) : data_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_d;
      rs_q   <= rs_d;
      byte_q <= byte_d;
    end
  end

  always_comb begin
    sel_rs    = 1'b0;
    sel_rw    = 1'b0;
    sel_nib   = 4'h0;
    sel_wait  = WAIT_SHORT;
    last_step = 1'b0;
    unique case (req_q) inside
      REQ_INIT: begin
        last_step = (step_i == LastStepInit);
        unique case (step_i) inside
          4'd0, 4'd1, 4'd2: begin
            sel_nib  = NIB_WAKE;
            sel_wait = WAIT_WAKE;
          end
          4'd3: begin
            sel_nib  = NIB_FOUR_BIT;
            sel_wait = WAIT_CMD;
          end
          4'd4: sel_nib = fs_q[7:4];
          4'd5: begin
            sel_nib  = fs_q[3:0];
            sel_wait = WAIT_CMD;
          end
          4'd6: sel_nib = dc_q[7:4];
          4'd7: begin
            sel_nib  = dc_q[3:0];
            sel_wait = WAIT_CMD;
          end
          4'd8: sel_nib = CMD_CLEAR[7:4];
          4'd9: begin
            sel_nib  = CMD_CLEAR[3:0];
            sel_wait = WAIT_LONG;
          end
          4'd10: sel_nib = em_q[7:4];
          4'd11: begin
            sel_nib  = em_q[3:0];
            sel_wait = WAIT_LONG;
          end
          4'd12: sel_rw = 1'b1;
          default: begin
            sel_rw   = 1'b1;
            sel_wait = WAIT_INIT_BUSY;
          end
        endcase
      end
      REQ_WRITE, REQ_GOTO: begin
        last_step = (step_i == LastStepByte);
        unique case (step_i)
          4'd0: sel_rw = 1'b1;
          4'd1: begin
            sel_rw   = 1'b1;
            sel_wait = WAIT_BUSY;
          end
          4'd2: begin
            sel_rs  = rs_q;
            sel_nib = byte_q[7:4];
          end
          default: begin
            sel_rs   = rs_q;
            sel_nib  = byte_q[3:0];
            sel_wait = (req_q == REQ_GOTO) ? WAIT_GOTO : WAIT_DATA;
          end
        endcase
      end
      REQ_CLEAR: begin
        last_step = (step_i == LastStepClear);
        unique case (step_i)
          4'd0: sel_nib = CMD_CLEAR[7:4];
          default: begin
            sel_nib  = CMD_CLEAR[3:0];
            sel_wait = WAIT_CLEAR;
          end
        endcase
      end
      default: last_step = 1'b1;
    endcase
  end

  assign status_o.last_step = last_step;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rs_out_q   <= sel_rs;
      rw_out_q   <= sel_rw;
      nib_out_q  <= sel_nib;
      wait_out_q <= sel_wait;
      last_out_q <= last_step;
    end
  end

  assign rs_line_o       = rs_out_q;
  assign rw_line_o       = rw_out_q;
  assign nibble_o        = nib_out_q;
  assign wait_after_us_o = wait_out_q;
  assign last_o          = last_out_q;

endmodule

@@ rtl/cls_checker.sv @@
// ----------------------------------------------------------------------------
// cls_checker
// Port-level checks of the character LCD sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "char_lcd_4bit_sequencer_macros.svh"

module cls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [7:0]  cfg_data_i,
  input logic        req_valid_i,
  input logic        req_stall_o,
  input logic [1:0]  req_type_i,
  input logic        reg_select_i,
  input logic [7:0]  data_byte_i,
  input logic [4:0]  column_i,
  input logic [1:0]  row_i,
  input logic        strobe_valid_o,
  input logic        strobe_stall_i,
  input logic        rs_line_o,
  input logic        rw_line_o,
  input logic [3:0]  nibble_o,
  input logic [15:0] wait_after_us_o,
  input logic        last_o
);

  `CLS_ASSERT(a_stall_holds_valid, clk_i, rst_ni,
              strobe_valid_o && strobe_stall_i |=> strobe_valid_o,
              "strobe word dropped while stalled")

  `CLS_ASSERT(a_stall_holds_word, clk_i, rst_ni,
              strobe_valid_o && strobe_stall_i |=> $stable(nibble_o) &&
              $stable(wait_after_us_o) && $stable(last_o) && $stable(rs_line_o) &&
              $stable(rw_line_o),
              "strobe word changed while stalled")

  `CLS_ASSERT(a_busy_after_accept, clk_i, rst_ni,
              req_valid_i && !req_stall_o |=> req_stall_o,
              "request taken while a request is in progress")

  `CLS_ASSERT(a_read_strobe_clean, clk_i, rst_ni,
              strobe_valid_o && rw_line_o |-> nibble_o == 4'h0 && !rs_line_o,
              "read strobe with data or RS set")

  `CLS_ASSERT(a_gap_after_last, clk_i, rst_ni,
              strobe_valid_o && last_o && !strobe_stall_i && !req_stall_o |=> !strobe_valid_o,
              "strobe word right after the last strobe")

endmodule

bind char_lcd_4bit_sequencer cls_checker u_cls_checker (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Character LCD 4-bit sequencer testbench
// Drives init, write, goto and clear requests through the request channel,
// predicts every strobe word from a local model of the bus sequences and the
// register shadow, and checks each accepted strobe word in order. Register
// settings change between phases; the request channel idles and the strobe channel stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cls_pkg::*;

  typedef struct packed {
    req_e       kind;
    logic       rs;
    logic [7:0] data;
    logic [4:0] col;
    logic [1:0] row;
  } lcd_req_t;

  typedef struct packed {
    lcd_req_t   req;
    logic       typed;
    logic [7:0] want_byte;
  } lcd_row_t;

  typedef struct packed {
    logic        rs;
    logic        rw;
    logic [3:0]  nibble;
    logic [15:0] wait_us;
    logic        last;
  } lcd_strobe_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        req_valid_i;
  logic        req_stall_o;
  logic [1:0]  req_type_i;
  logic        reg_select_i;
  logic [7:0]  data_byte_i;
  logic [4:0]  column_i;
  logic [1:0]  row_i;
  logic        strobe_valid_o;
  logic        strobe_stall_i;
  logic        rs_line_o;
  logic        rw_line_o;
  logic [3:0]  nibble_o;
  logic [15:0] wait_after_us_o;
  logic        last_o;

  lcd_strobe_t pending_strobes[$];

  logic [7:0] fs_word;
  logic [7:0] dc_word;
  logic [7:0] em_word;
  logic [6:0] row_base;

  int mismatches = 0;
  int strobes_seen = 0;
  int req_count [4] = '{0, 0, 0, 0};
  int settings_used = 1;

  bit calm = 1'b0;
  int gap_pct = 20;
  int stall_pct = 20;
  int stall_left = 0;
  bit squeeze_arm = 1'b0;
  bit squeeze = 1'b0;

  lcd_row_t directed_rows [18] = '{
    '{'{REQ_INIT,  1'b0, 8'h00, 5'd0,  2'd0}, 1'b0, 8'h00},
    '{'{REQ_CLEAR, 1'b0, 8'h00, 5'd0,  2'd0}, 1'b1, 8'h01},
    '{'{REQ_WRITE, 1'b0, 8'h00, 5'd0,  2'd0}, 1'b1, 8'h00},
    '{'{REQ_WRITE, 1'b1, 8'hFF, 5'd0,  2'd0}, 1'b1, 8'hFF},
    '{'{REQ_WRITE, 1'b1, 8'hA5, 5'd0,  2'd0}, 1'b1, 8'hA5},
    '{'{REQ_WRITE, 1'b0, 8'h5A, 5'd0,  2'd0}, 1'b1, 8'h5A},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd1,  2'd1}, 1'b1, 8'h80},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd16, 2'd2}, 1'b1, 8'hCF},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd0,  2'd1}, 1'b1, 8'hFF},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd31, 2'd1}, 1'b1, 8'h9E},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd5,  2'd0}, 1'b1, 8'h84},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd5,  2'd3}, 1'b1, 8'hC4},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd31, 2'd3}, 1'b1, 8'hDE},
    '{'{REQ_GOTO,  1'b0, 8'h00, 5'd0,  2'd2}, 1'b1, 8'hBF},
    '{'{REQ_INIT,  1'b1, 8'hFF, 5'd31, 2'd3}, 1'b0, 8'h00},
    '{'{REQ_CLEAR, 1'b1, 8'hFF, 5'd31, 2'd3}, 1'b1, 8'h01},
    '{'{REQ_WRITE, 1'b1, 8'h3C, 5'd31, 2'd3}, 1'b1, 8'h3C},
    '{'{REQ_GOTO,  1'b1, 8'hFF, 5'd8,  2'd2}, 1'b1, 8'hC7}
  };

  char_lcd_4bit_sequencer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .req_type_i     (req_type_i),
    .reg_select_i   (reg_select_i),
    .data_byte_i    (data_byte_i),
    .column_i       (column_i),
    .row_i          (row_i),
    .strobe_valid_o (strobe_valid_o),
    .strobe_stall_i (strobe_stall_i),
    .rs_line_o      (rs_line_o),
    .rw_line_o      (rw_line_o),
    .nibble_o       (nibble_o),
    .wait_after_us_o(wait_after_us_o),
    .last_o         (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endfunction

  function automatic void push_strobe(input logic rs, input logic rw, input logic [3:0] nib,
                                      input logic [15:0] wait_us, input logic fin);
    pending_strobes.push_back('{rs, rw, nib, wait_us, fin});
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] value,
                                    input logic [15:0] wait_low, input logic fin);
    push_strobe(rs, 1'b0, value[7:4], 16'd2, 1'b0);
    push_strobe(rs, 1'b0, value[3:0], wait_low, fin);
  endfunction

  function automatic void push_busy_read(input logic [15:0] wait_us, input logic fin);
    push_strobe(1'b0, 1'b1, 4'h0, 16'd2, 1'b0);
    push_strobe(1'b0, 1'b1, 4'h0, wait_us, fin);
  endfunction

  function automatic void expand_request(input lcd_req_t r, input logic typed,
                                         input logic [7:0] typed_byte);
    logic [7:0] addr;
    addr = CMD_SET_DDRAM | 8'((r.row > 2'd1 ? {1'b0, row_base} : 8'd0) + {3'b0, r.col} - 8'd1);
    case (r.kind)
      REQ_INIT: begin
        push_strobe(1'b0, 1'b0, 4'h3, 16'd5002, 1'b0);
        push_strobe(1'b0, 1'b0, 4'h3, 16'd5002, 1'b0);
        push_strobe(1'b0, 1'b0, 4'h3, 16'd5002, 1'b0);
        push_strobe(1'b0, 1'b0, 4'h2, 16'd252, 1'b0);
        push_byte(1'b0, fs_word, 16'd252, 1'b0);
        push_byte(1'b0, dc_word, 16'd252, 1'b0);
        push_byte(1'b0, CMD_CLEAR, 16'd25002, 1'b0);
        push_byte(1'b0, em_word, 16'd25002, 1'b0);
        push_busy_read(16'd40052, 1'b1);
      end
      REQ_WRITE: begin
        push_busy_read(16'd52, 1'b0);
        push_byte(r.rs, typed ? typed_byte : r.data, 16'd50, 1'b1);
      end
      REQ_GOTO: begin
        push_busy_read(16'd52, 1'b0);
        push_byte(1'b0, typed ? typed_byte : addr, 16'd100, 1'b1);
      end
      default: begin
        push_byte(1'b0, typed ? typed_byte : CMD_CLEAR, 16'd5002, 1'b1);
      end
    endcase
  endfunction

  function automatic lcd_req_t random_request();
    lcd_req_t r;
    r.kind = req_e'($urandom_range(0, 3));
    r.rs = 1'($urandom_range(0, 1));
    r.data = 8'($urandom_range(0, 255));
    r.col = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(1, 16))
                                        : 5'($urandom_range(0, 31));
    r.row = ($urandom_range(0, 4) != 0) ? 2'($urandom_range(1, 2))
                                        : 2'($urandom_range(0, 3));
    return r;
  endfunction

  task automatic rest_requests(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      req_valid_i = 1'b0;
      {req_type_i, reg_select_i, data_byte_i, column_i, row_i} = 18'($urandom);
    end
  endtask

  task automatic offer_request(input lcd_req_t r, input logic typed, input logic [7:0] typed_byte);
    @(negedge clk_i);
    req_valid_i = 1'b1;
    req_type_i = r.kind;
    reg_select_i = r.rs;
    data_byte_i = r.data;
    column_i = r.col;
    row_i = r.row;
    do @(posedge clk_i); while (req_stall_o);
    expand_request(r, typed, typed_byte);
    req_count[r.kind]++;
  endtask

  task automatic drain_strobes();
    rest_requests(1);
    while (pending_strobes.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [7:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FUNCTION_SET:    fs_word = value;
      CFG_DISPLAY_CONTROL: dc_word = value;
      CFG_ENTRY_MODE:      em_word = value;
      default:             row_base = value[6:0];
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // receiver: random stall bursts plus one long hold-off
  initial begin
    strobe_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 14);
      end
      strobe_stall_i = squeeze || (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  initial begin
    wait (squeeze_arm);
    @(posedge clk_i);
    squeeze = 1'b1;
    repeat (150) @(posedge clk_i);
    squeeze = 1'b0;
  end

  always @(posedge clk_i) begin
    lcd_strobe_t got;
    lcd_strobe_t want;
    if (rst_ni && strobe_valid_o && !strobe_stall_i) begin
      got = '{rs_line_o, rw_line_o, nibble_o, wait_after_us_o, last_o};
      strobes_seen++;
      if (pending_strobes.size() == 0) begin
        note_mismatch($sformatf("unexpected word rs=%0b rw=%0b nib=%h wait=%0d last=%0b",
                                got.rs, got.rw, got.nibble, got.wait_us, got.last));
      end else begin
        want = pending_strobes.pop_front();
        if (got.rs !== want.rs || got.rw !== want.rw || got.nibble !== want.nibble ||
            got.wait_us !== want.wait_us || got.last !== want.last) begin
          note_mismatch($sformatf({"word %0d: expected rs=%0b rw=%0b nib=%h wait=%0d last=%0b,",
                                   " got rs=%0b rw=%0b nib=%h wait=%0d last=%0b"},
                                  strobes_seen, want.rs, want.rw, want.nibble, want.wait_us,
                                  want.last, got.rs, got.rw, got.nibble, got.wait_us,
                                  got.last));
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    logic [7:0] new_fs;
    logic [7:0] new_dc;
    logic [7:0] new_em;
    logic [7:0] new_rb;
    fs_word = 8'h28;
    dc_word = 8'h0F;
    em_word = 8'h06;
    row_base = 7'h40;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    req_valid_i = 1'b0;
    req_type_i = '0;
    reg_select_i = 1'b0;
    data_byte_i = '0;
    column_i = '0;
    row_i = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) begin
      if ($urandom_range(0, 99) < gap_pct) rest_requests($urandom_range(1, 14));
      offer_request(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].want_byte);
    end

    for (int p = 0; p < 5; p++) begin
      drain_strobes();
      case (p)
        0: begin
          {new_fs, new_dc, new_em, new_rb} = '0;
          gap_pct = 30;
          stall_pct = 30;
        end
        1: begin
          {new_fs, new_dc, new_em, new_rb} = '1;
          gap_pct = 0;
          stall_pct = 40;
        end
        4: begin
          {new_fs, new_dc, new_em, new_rb} = $urandom;
          calm = 1'b1;
        end
        default: begin
          {new_fs, new_dc, new_em, new_rb} = $urandom;
          gap_pct = (p == 2) ? 40 : 25;
          stall_pct = (p == 2) ? 0 : 25;
        end
      endcase
      write_register(CFG_FUNCTION_SET, new_fs);
      write_register(CFG_DISPLAY_CONTROL, new_dc);
      write_register(CFG_ENTRY_MODE, new_em);
      write_register(CFG_SECOND_ROW, new_rb);
      settings_used++;
      for (int i = 0; i < 38; i++) begin
        if (p == 3 && i == 8) squeeze_arm = 1'b1;
        if (!calm && $urandom_range(0, 99) < gap_pct) rest_requests($urandom_range(1, 14));
        offer_request(random_request(), 1'b0, 8'h00);
      end
    end

    drain_strobes();
    repeat (20) @(posedge clk_i);
    if (pending_strobes.size() != 0) begin
      note_mismatch($sformatf("%0d strobe words never arrived", pending_strobes.size()));
    end
    $display("covered %0d init, %0d write, %0d goto, %0d clear requests under %0d %s",
             req_count[REQ_INIT], req_count[REQ_WRITE], req_count[REQ_GOTO],
             req_count[REQ_CLEAR], settings_used, "register settings");
    $display("checked %0d strobe words, %0d mismatches", strobes_seen, mismatches);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cls_pkg.sv
rtl/cls_ctrl.sv
rtl/cls_datapath.sv
rtl/char_lcd_4bit_sequencer.sv
rtl/cls_checker.sv
dv/testbench.sv
